// ===== hw/rtl/ouesort_pkg.sv =====
// Shared constants, payload structs and the sort-key function of the sorter.
// No dependencies; used by odd_up_even_down_sorter.
package ouesort_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int DATA_W    = 32;
    localparam int KEY_W     = DATA_W + 1;

    typedef logic [KEY_W-1:0] t_key;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last_item;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     end_of_run;
        logic                     overflowed;
    } t_out_item;

    // Maps a word to an unsigned key whose ascending order is the emitted order:
    // odd words first (ascending), then even words (descending).
    function automatic t_key sort_key(input logic [DATA_W-1:0] w);
        logic [DATA_W-1:0] biased;
        biased = w ^ {1'b1, {(DATA_W-1){1'b0}}};
        if (w[0]) begin
            sort_key = {1'b0, biased};
        end else begin
            sort_key = {1'b1, ~biased};
        end
    endfunction

endpackage

// ===== hw/rtl/odd_up_even_down_sorter.sv =====
// Top level of the odd-up / even-down sorter: load store, selection scan, result register.
// Depends on ouesort_pkg.
//
// Usage: words arrive one per transfer (start high while busy low). Each word
// is written to a 64-entry store; words beyond capacity are dropped and set the
// overflow flag for the set. The transfer that carries last_item starts the
// emission and busy rises. Emission is a selection sort: for each output rank
// one shared key comparator walks the stored words through the registered read
// port, picking the smallest key not yet emitted; results come out on o_strobe,
// one cycle each, and must be taken in that cycle since the receiver cannot
// stall. end_of_run marks the final result, and busy drops in the cycle that
// result is shown, so the next set can begin loading immediately. No clearing
// pass is needed after reset.
module odd_up_even_down_sorter (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    input  ouesort_pkg::t_in_item  i_item,
    output logic                   busy,
    output logic                   o_strobe,
    output ouesort_pkg::t_out_item o_result
);
    import ouesort_pkg::*;

    typedef enum logic {
        S_LOAD,
        S_SCAN
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_count;
    logic                r_ovf;
    logic [ADDR_W-1:0]   r_last_idx;
    logic [ADDR_W-1:0]   r_rank;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_issuing;
    logic                r_rd_vld;
    logic [ADDR_W-1:0]   r_rd_idx;
    logic [DATA_W-1:0]   r_rd_data;
    logic [MAX_ITEMS-1:0] r_used;
    logic                r_found;
    t_key                r_best_key;
    logic [DATA_W-1:0]   r_best_val;
    logic [ADDR_W-1:0]   r_best_idx;
    logic                r_strobe;
    t_out_item           r_result;

    logic [DATA_W-1:0]   r_mem [MAX_ITEMS];

    logic                accept;
    logic                room;
    logic [CNT_W-1:0]    n_count;
    t_key                cand_key;
    logic                better;
    logic                fin;
    logic [DATA_W-1:0]   n_best_val;
    logic [ADDR_W-1:0]   n_best_idx;
    t_key                n_best_key;

    assign accept  = start && (r_state == S_LOAD);
    assign room    = r_count < CNT_W'(MAX_ITEMS);
    assign n_count = room ? r_count + CNT_W'(1) : r_count;

    // Shared comparator: candidate from the read port against the running best
    assign cand_key   = sort_key(r_rd_data);
    assign better     = r_rd_vld && !r_used[r_rd_idx] && (!r_found || (cand_key < r_best_key));
    assign fin        = r_rd_vld && (r_rd_idx == r_last_idx);
    assign n_best_val = better ? r_rd_data : r_best_val;
    assign n_best_idx = better ? r_rd_idx : r_best_idx;
    assign n_best_key = better ? cand_key : r_best_key;

    // Store: written on load transfers that find room, read once per scan cycle
    always_ff @(posedge i_clk) begin
        if (accept && room) begin
            r_mem[r_count[ADDR_W-1:0]] <= i_item.value;
        end
        r_rd_data <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_issuing  <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_found    <= 1'b0;
            r_strobe   <= 1'b0;
            r_used     <= '0;
            r_addr     <= '0;
            r_rank     <= '0;
            r_last_idx <= '0;
        end else begin
            r_strobe <= 1'b0;
            r_rd_vld <= r_issuing;
            r_rd_idx <= r_addr;
            case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        r_count <= n_count;
                        if (!room) begin
                            r_ovf <= 1'b1;
                        end
                        if (i_item.last_item) begin
                            r_last_idx <= ADDR_W'(n_count - CNT_W'(1));
                            r_rank     <= '0;
                            r_addr     <= '0;
                            r_issuing  <= 1'b1;
                            r_found    <= 1'b0;
                            r_used     <= '0;
                            r_state    <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_issuing) begin
                        if (r_addr == r_last_idx) begin
                            r_issuing <= 1'b0;
                        end else begin
                            r_addr <= r_addr + ADDR_W'(1);
                        end
                    end
                    if (fin) begin
                        // Pass complete: emit the winner and mark it used
                        r_strobe                <= 1'b1;
                        r_result.sorted_value   <= n_best_val;
                        r_result.end_of_run     <= (r_rank == r_last_idx);
                        r_result.overflowed     <= r_ovf;
                        r_used[n_best_idx]      <= 1'b1;
                        r_found                 <= 1'b0;
                        if (r_rank == r_last_idx) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_rank    <= r_rank + ADDR_W'(1);
                            r_addr    <= '0;
                            r_issuing <= 1'b1;
                        end
                    end else if (r_rd_vld) begin
                        r_found    <= r_found || better;
                        r_best_val <= n_best_val;
                        r_best_idx <= n_best_idx;
                        r_best_key <= n_best_key;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_LOAD);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ITEMS))
        else $error("item count beyond capacity");

    a_strobe_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_state == S_SCAN))
        else $error("result without a scan pass");

    a_end_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_result.end_of_run) |-> (r_state == S_LOAD && r_count == '0 && !r_ovf))
        else $error("set not cleared after final result");

    a_winner_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && fin) |-> (r_found || better))
        else $error("scan pass ended without a candidate");
`endif

endmodule
